[rtl/rgbhsl_pkg.sv]
package rgbhsl_pkg;

   // pixel component and result field widths
   localparam int COMP_W = 8;
   localparam int HUE_W  = 15;
   localparam int SAT_W  = 17;
   localparam int LIT_W  = 9;

   // sextant numerator: at most 6 * 255
   localparam int SEXT_W = 11;
   // sextant numerator times 60 degrees: at most 91800
   localparam int PROD_W = 17;

   // largest max + min that still uses the sum itself as denominator
   localparam logic [LIT_W-1:0] LIT_HALF = LIT_W'(255);
   // max + min of a white pixel
   localparam logic [LIT_W-1:0] LIT_FULL = LIT_W'(510);

endpackage

[rtl/rgbhsl_if.sv]
interface rgbhsl_req_if
   import rgbhsl_pkg::*;
   ;
   logic              valid;
   logic              ready;
   logic [COMP_W-1:0] red;
   logic [COMP_W-1:0] green;
   logic [COMP_W-1:0] blue;

   modport source (output valid, output red, output green, output blue, input ready);
   modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

interface rgbhsl_rsp_if
   import rgbhsl_pkg::*;
   ;
   logic             valid;
   logic             ready;
   logic [HUE_W-1:0] hue;
   logic [SAT_W-1:0] saturation;
   logic [LIT_W-1:0] lightness_sum;

   modport source (output valid, output hue, output saturation, output lightness_sum,
                   input ready);
   modport sink   (input valid, input hue, input saturation, input lightness_sum,
                   output ready);
endinterface

[rtl/rgb_to_hsl_converter_top.sv]
// throughput: one pixel per cycle while rsp does not stall; the latency is set by the two dividers,
// which resolve one quotient bit per pipeline stage
// the whole pipeline advances together and holds while a finished beat waits on rsp
// reset (synchronous) clears the valid bits only; no other state is kept
module rgb_to_hsl_converter_top
   import rgbhsl_pkg::*;
#(
   parameter int HUE_FRAC_BITS = 6,
   parameter int SAT_FRAC_BITS = 16
) (
   input  logic                clock,
   input  logic                reset,
   rgbhsl_req_if.sink          req,
   rgbhsl_rsp_if.source        rsp
);

   // hue quotient reaches 360 << HUE_FRAC_BITS, saturation quotient 1 << SAT_FRAC_BITS
   localparam int HUE_QW    = 9 + HUE_FRAC_BITS;
   localparam int SAT_QW    = 1 + SAT_FRAC_BITS;
   localparam int HUE_NUM_W = PROD_W + HUE_FRAC_BITS;
   localparam int SAT_NUM_W = COMP_W + SAT_FRAC_BITS;
   localparam int DIV_LAT   = (HUE_QW > SAT_QW) ? HUE_QW : SAT_QW;

   // global advance: move on whenever the output register is empty or being taken
   logic adv;

   // stage 1: inputs with max and min
   logic              s1_valid_ff;
   logic [COMP_W-1:0] s1_red_ff, s1_green_ff, s1_blue_ff;
   logic [COMP_W-1:0] s1_max_ff, s1_min_ff;
   logic [COMP_W-1:0] s1_max_in, s1_min_in;

   // stage 2: sum, difference, saturation denominator, sextant numerator
   logic              s2_valid_ff;
   logic [LIT_W-1:0]  s2_lit_ff;
   logic [COMP_W-1:0] s2_diff_ff;
   logic [COMP_W-1:0] s2_den_ff;
   logic [SEXT_W-1:0] s2_sext_ff;
   logic              s2_zero_ff;
   logic [LIT_W-1:0]  s2_lit_in;
   logic [COMP_W-1:0] s2_diff_in;
   logic [COMP_W-1:0] s2_den_in;
   logic [SEXT_W-1:0] s2_sext_in;

   // stage 3: divider operands
   logic                 s3_valid_ff;
   logic [LIT_W-1:0]     s3_lit_ff;
   logic [HUE_NUM_W-1:0] s3_hue_num_ff;
   logic [COMP_W-1:0]    s3_hue_den_ff;
   logic [SAT_NUM_W-1:0] s3_sat_num_ff;
   logic [COMP_W-1:0]    s3_sat_den_ff;
   logic [PROD_W-1:0]    s3_prod_in;

   // side band that travels alongside the dividers
   logic             dly_valid_ff [DIV_LAT];
   logic [LIT_W-1:0] dly_lit_ff   [DIV_LAT];

   logic [HUE_QW-1:0] hue_quo;
   logic [SAT_QW-1:0] sat_quo;

   assign adv       = !rsp.valid || rsp.ready;
   assign req.ready = adv;

   // ---------------------------------------------------------------- stage 1
   always_comb begin
      s1_max_in = (req.red > req.green) ? req.red : req.green;
      s1_max_in = (s1_max_in > req.blue) ? s1_max_in : req.blue;
      s1_min_in = (req.red < req.green) ? req.red : req.green;
      s1_min_in = (s1_min_in < req.blue) ? s1_min_in : req.blue;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= req.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_red_ff   <= req.red;
         s1_green_ff <= req.green;
         s1_blue_ff  <= req.blue;
         s1_max_ff   <= s1_max_in;
         s1_min_ff   <= s1_min_in;
      end
   end

   // ---------------------------------------------------------------- stage 2
   // sextant value times the difference; ties for max go to red, then green
   always_comb begin
      logic [SEXT_W-1:0] d_ext;
      logic [SEXT_W-1:0] to_r, to_g, to_b;

      d_ext = SEXT_W'(s1_max_ff - s1_min_ff);
      to_r  = SEXT_W'(s1_max_ff - s1_red_ff);
      to_g  = SEXT_W'(s1_max_ff - s1_green_ff);
      to_b  = SEXT_W'(s1_max_ff - s1_blue_ff);

      s2_diff_in = s1_max_ff - s1_min_ff;
      s2_lit_in  = LIT_W'(s1_max_ff) + LIT_W'(s1_min_ff);
      s2_den_in  = (s2_lit_in <= LIT_HALF) ? s2_lit_in[COMP_W-1:0]
                                           : COMP_W'(LIT_FULL - s2_lit_in);

      priority if (s1_red_ff == s1_max_ff) begin
         // red on top: green at the bottom wraps to the magenta side
         s2_sext_in = (s1_green_ff == s1_min_ff) ? ((d_ext << 2) + d_ext + to_b)
                                                 : (d_ext - to_g);
      end else if (s1_green_ff == s1_max_ff) begin
         s2_sext_in = (s1_blue_ff == s1_min_ff) ? (d_ext + to_r)
                                                : ((d_ext << 1) + d_ext - to_b);
      end else begin
         s2_sext_in = (s1_red_ff == s1_min_ff) ? ((d_ext << 1) + d_ext + to_g)
                                               : ((d_ext << 2) + d_ext - to_r);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (adv) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s2_lit_ff  <= s2_lit_in;
         s2_diff_ff <= s2_diff_in;
         s2_den_ff  <= s2_den_in;
         s2_sext_ff <= s2_sext_in;
         // grey and black: max equals min
         s2_zero_ff <= (s2_diff_in == '0);
      end
   end

   // ---------------------------------------------------------------- stage 3
   // times 60 as 64 - 4; a zero numerator over one forces hue and saturation to zero
   assign s3_prod_in = (PROD_W'(s2_sext_ff) << 6) - (PROD_W'(s2_sext_ff) << 2);

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (adv) begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s3_lit_ff <= s2_lit_ff;
         if (s2_zero_ff) begin
            s3_hue_num_ff <= '0;
            s3_hue_den_ff <= COMP_W'(1);
            s3_sat_num_ff <= '0;
            s3_sat_den_ff <= COMP_W'(1);
         end else begin
            s3_hue_num_ff <= HUE_NUM_W'(s3_prod_in) << HUE_FRAC_BITS;
            s3_hue_den_ff <= s2_diff_ff;
            s3_sat_num_ff <= SAT_NUM_W'(s2_diff_ff) << SAT_FRAC_BITS;
            s3_sat_den_ff <= s2_den_ff;
         end
      end
   end

   // ---------------------------------------------------------------- dividers
   rgbhsl_div #(
      .NUM_W (HUE_NUM_W),
      .QUO_W (HUE_QW),
      .DEN_W (COMP_W),
      .LAT   (DIV_LAT)
   ) u_hue_div (
      .clock (clock),
      .en    (adv),
      .num   (s3_hue_num_ff),
      .den   (s3_hue_den_ff),
      .quo   (hue_quo)
   );

   rgbhsl_div #(
      .NUM_W (SAT_NUM_W),
      .QUO_W (SAT_QW),
      .DEN_W (COMP_W),
      .LAT   (DIV_LAT)
   ) u_sat_div (
      .clock (clock),
      .en    (adv),
      .num   (s3_sat_num_ff),
      .den   (s3_sat_den_ff),
      .quo   (sat_quo)
   );

   // valid and lightness follow the divider stages one for one
   for (genvar k = 0; k < DIV_LAT; k++) begin : g_dly
      logic             valid_prev;
      logic [LIT_W-1:0] lit_prev;

      if (k == 0) begin : g_first
         assign valid_prev = s3_valid_ff;
         assign lit_prev   = s3_lit_ff;
      end else begin : g_next
         assign valid_prev = dly_valid_ff[k-1];
         assign lit_prev   = dly_lit_ff[k-1];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            dly_valid_ff[k] <= 1'b0;
         end else if (adv) begin
            dly_valid_ff[k] <= valid_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            dly_lit_ff[k] <= lit_prev;
         end
      end
   end

   // ---------------------------------------------------------------- result beat
   // the last divider stage is the output register
   assign rsp.valid         = dly_valid_ff[DIV_LAT-1];
   assign rsp.hue           = HUE_W'(hue_quo);
   assign rsp.saturation    = SAT_W'(sat_quo);
   assign rsp.lightness_sum = dly_lit_ff[DIV_LAT-1];

endmodule

[rtl/rgbhsl_div.sv]
// pipelined restoring divider, one quotient bit per stage, extra stages only delay
module rgbhsl_div #(
   parameter int NUM_W = 23,
   parameter int QUO_W = 15,
   parameter int DEN_W = 8,
   parameter int LAT   = 17
) (
   input  logic             clock,
   input  logic             en,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic [QUO_W-1:0] quo
);

   localparam int EXT_W = NUM_W + DEN_W;

   logic [EXT_W-1:0] num_ext;
   logic [DEN_W-1:0] rem_init;

   logic [DEN_W-1:0] rem_ff [LAT];
   logic [QUO_W-1:0] shf_ff [LAT];
   logic [DEN_W-1:0] div_ff [LAT];

   // quotient fits QUO_W bits, so the top part of the dividend is already below den
   assign num_ext  = EXT_W'(num);
   assign rem_init = num_ext[QUO_W +: DEN_W];

   for (genvar k = 0; k < LAT; k++) begin : g_stage
      logic [DEN_W-1:0] rem_prev;
      logic [QUO_W-1:0] shf_prev;
      logic [DEN_W-1:0] div_prev;
      logic [DEN_W-1:0] rem_in;
      logic [QUO_W-1:0] shf_in;

      if (k == 0) begin : g_first
         assign rem_prev = rem_init;
         assign shf_prev = num[QUO_W-1:0];
         assign div_prev = den;
      end else begin : g_next
         assign rem_prev = rem_ff[k-1];
         assign shf_prev = shf_ff[k-1];
         assign div_prev = div_ff[k-1];
      end

      if (k < QUO_W) begin : g_step
         logic [DEN_W:0] trial;
         logic [DEN_W:0] diff;
         logic           ge;

         always_comb begin
            trial  = {rem_prev, shf_prev[QUO_W-1]};
            diff   = trial - {1'b0, div_prev};
            ge     = (trial >= {1'b0, div_prev});
            rem_in = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            shf_in = {shf_prev[QUO_W-2:0], ge};
         end
      end else begin : g_hold
         assign rem_in = rem_prev;
         assign shf_in = shf_prev;
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k] <= rem_in;
            shf_ff[k] <= shf_in;
            div_ff[k] <= div_prev;
         end
      end
   end

   assign quo = shf_ff[LAT-1];

endmodule

[bench/rgb_to_hsl_converter_top_test.sv]
module rgb_to_hsl_converter_top_test
   import rgbhsl_pkg::*;
   ;

   timeunit 1ns;
   timeprecision 1ps;

   // fraction widths the block is built with, and used by the prediction below
   localparam int HUE_FRAC = 6;
   localparam int SAT_FRAC = 16;

   // pipeline depth of the block, with margin for the final drain
   localparam int PIPE_DEPTH   = 3 + ((9 + HUE_FRAC) > (1 + SAT_FRAC) ?
                                      (9 + HUE_FRAC) : (1 + SAT_FRAC));
   localparam int DRAIN_CYCLES = 2 * PIPE_DEPTH;

   // one converted pixel, in the block's own field widths
   typedef struct packed {
      logic [HUE_W-1:0] hue;
      logic [SAT_W-1:0] saturation;
      logic [LIT_W-1:0] lightness_sum;
   } hsl_type;

   // a pixel that was taken in, with the colour it must turn into
   typedef struct packed {
      logic [COMP_W-1:0] red;
      logic [COMP_W-1:0] green;
      logic [COMP_W-1:0] blue;
      hsl_type           colour;
   } pending_pixel_type;

   logic clock;
   logic reset;

   rgbhsl_req_if req_link ();
   rgbhsl_rsp_if rsp_link ();

   rgb_to_hsl_converter_top #(
      .HUE_FRAC_BITS (HUE_FRAC),
      .SAT_FRAC_BITS (SAT_FRAC)
   ) dut (
      .clock (clock),
      .reset (reset),
      .req   (req_link),
      .rsp   (rsp_link)
   );

   // colours still owed by the block, oldest first
   pending_pixel_type pending_colours[$];

   int req_idle_pct;      // chance in a hundred that the sender leaves a gap
   int rsp_idle_pct;      // chance in a hundred that the receiver stalls
   int hold_off_left;     // cycles the receiver still refuses every beat
   int mismatches;
   int pixels_sent;
   int colours_checked;
   int input_stall_cycles;
   int grey_pixels;

   // clock: 8 ns period
   initial clock = 1'b0;
   always #4 clock = ~clock;

   // hard limit on run length, far beyond the slowest legal run
   initial begin
      #2ms;
      $display("rgb_to_hsl_converter_top regression: fail");
      $finish;
   end

   // ---------------------------------------------------------------------------------------
   // prediction
   // ---------------------------------------------------------------------------------------

   // hsl of one pixel: lightness kept as max + min, saturation and hue as truncated fixed
   // point; the sextant is picked with ties for the max going to red, then green
   function automatic hsl_type hsl_of_pixel(input logic [COMP_W-1:0] r,
                                            input logic [COMP_W-1:0] g,
                                            input logic [COMP_W-1:0] b);
      int unsigned rv, gv, bv;
      int unsigned brightest, darkest, sum, spread, den, sext;
      hsl_type     colour;
      rv = r;
      gv = g;
      bv = b;
      brightest = (rv > gv) ? rv : gv;
      brightest = (brightest > bv) ? brightest : bv;
      darkest   = (rv < gv) ? rv : gv;
      darkest   = (darkest < bv) ? darkest : bv;
      sum    = brightest + darkest;
      spread = brightest - darkest;
      colour.hue           = '0;
      colour.saturation    = '0;
      colour.lightness_sum = LIT_W'(sum);
      // black and greys keep hue and saturation at zero
      if (sum != 0 && spread != 0) begin
         den = (sum <= 255) ? sum : (510 - sum);
         colour.saturation = SAT_W'((spread << SAT_FRAC) / den);
         // sextant value scaled by the spread, never negative
         if (rv == brightest) begin
            sext = (gv == darkest) ? (5 * spread + (brightest - bv))
                                   : (spread - (brightest - gv));
         end else if (gv == brightest) begin
            sext = (bv == darkest) ? (spread + (brightest - rv))
                                   : (3 * spread - (brightest - bv));
         end else begin
            sext = (rv == darkest) ? (3 * spread + (brightest - gv))
                                   : (5 * spread - (brightest - rv));
         end
         colour.hue = HUE_W'(((sext * 60) << HUE_FRAC) / spread);
      end
      return colour;
   endfunction

   // ---------------------------------------------------------------------------------------
   // checking
   // ---------------------------------------------------------------------------------------

   // one line per mismatch
   task automatic report_mismatch(input string what);
      mismatches++;
      $display("mismatch at %0t ns: %s", $time, what);
   endtask

   task automatic check_colour(input hsl_type seen);
      pending_pixel_type want;
      if (pending_colours.size() == 0) begin
         report_mismatch($sformatf("unexpected beat hue %0d sat %0d light %0d",
                                   seen.hue, seen.saturation, seen.lightness_sum));
      end else begin
         want = pending_colours.pop_front();
         colours_checked++;
         if (seen.hue !== want.colour.hue)
            report_mismatch($sformatf("rgb %0d,%0d,%0d hue %0d, want %0d", want.red,
                                      want.green, want.blue, seen.hue, want.colour.hue));
         if (seen.saturation !== want.colour.saturation)
            report_mismatch($sformatf("rgb %0d,%0d,%0d saturation %0d, want %0d", want.red,
                                      want.green, want.blue, seen.saturation,
                                      want.colour.saturation));
         if (seen.lightness_sum !== want.colour.lightness_sum)
            report_mismatch($sformatf("rgb %0d,%0d,%0d lightness %0d, want %0d", want.red,
                                      want.green, want.blue, seen.lightness_sum,
                                      want.colour.lightness_sum));
      end
   endtask

   // result monitor: counts req stalls, checks every rsp beat against the oldest owed colour
   always @(posedge clock) begin
      if (!reset) begin
         if (req_link.valid === 1'b1 && req_link.ready !== 1'b1)
            input_stall_cycles++;
         if (rsp_link.valid === 1'b1 && rsp_link.ready === 1'b1)
            check_colour('{hue: rsp_link.hue, saturation: rsp_link.saturation,
                           lightness_sum: rsp_link.lightness_sum});
      end
   end

   // receiver: random stalls, or a counted hold-off when one is asked for
   always @(negedge clock) begin
      if (hold_off_left > 0) begin
         rsp_link.ready <= 1'b0;
         hold_off_left  <= hold_off_left - 1;
      end else begin
         rsp_link.ready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   // ---------------------------------------------------------------------------------------
   // stimulus
   // ---------------------------------------------------------------------------------------

   // offers one pixel, with random gaps first; valid stays high after the beat so
   // that back-to-back pixels never drop it
   task automatic send_pixel(input logic [COMP_W-1:0] r,
                             input logic [COMP_W-1:0] g,
                             input logic [COMP_W-1:0] b);
      @(negedge clock);
      while ($urandom_range(99) < req_idle_pct) begin
         // idle cycle with junk on the data lines
         req_link.valid <= 1'b0;
         req_link.red   <= COMP_W'($urandom);
         req_link.green <= COMP_W'($urandom);
         req_link.blue  <= COMP_W'($urandom);
         @(negedge clock);
      end
      req_link.valid <= 1'b1;
      req_link.red   <= r;
      req_link.green <= g;
      req_link.blue  <= b;
      do @(posedge clock); while (req_link.ready !== 1'b1);
      pending_colours.push_back('{red: r, green: g, blue: b, colour: hsl_of_pixel(r, g, b)});
      pixels_sent++;
      if (r == g && g == b)
         grey_pixels++;
   endtask

   task automatic release_req();
      @(negedge clock);
      req_link.valid <= 1'b0;
   endtask

   task automatic wait_for_colours();
      while (pending_colours.size() != 0)
         @(posedge clock);
   endtask

   // puts three components onto the three channels in a random order
   task automatic shuffle_components(input  logic [COMP_W-1:0] x,
                                     input  logic [COMP_W-1:0] y,
                                     input  logic [COMP_W-1:0] z,
                                     output logic [COMP_W-1:0] r,
                                     output logic [COMP_W-1:0] g,
                                     output logic [COMP_W-1:0] b);
      case ($urandom_range(5))
         0: begin r = x; g = y; b = z; end
         1: begin r = x; g = z; b = y; end
         2: begin r = y; g = x; b = z; end
         3: begin r = y; g = z; b = x; end
         4: begin r = z; g = x; b = y; end
         default: begin r = z; g = y; b = x; end
      endcase
   endtask

   // random pixel, weighted towards greys, ties, primaries and the lightness midpoint
   task automatic pick_pixel(output logic [COMP_W-1:0] r,
                             output logic [COMP_W-1:0] g,
                             output logic [COMP_W-1:0] b);
      logic [COMP_W-1:0] x, y, z;
      int                top, target;
      x = COMP_W'($urandom);
      y = COMP_W'($urandom);
      z = COMP_W'($urandom);
      case ($urandom_range(9))
         0: begin
            // grey, black and white among them
            r = x; g = x; b = x;
         end
         1: begin
            // two components equal: ties for the max or for the min
            shuffle_components(x, x, y, r, g, b);
         end
         2: begin
            // each component fully off or fully on
            r = $urandom_range(1) ? '1 : '0;
            g = $urandom_range(1) ? '1 : '0;
            b = $urandom_range(1) ? '1 : '0;
         end
         3: begin
            // max + min around 255, where the saturation denominator switches
            top    = $urandom_range(130, 250);
            target = $urandom_range(253, 257);
            x      = COMP_W'(top);
            y      = COMP_W'(target - top);
            z      = COMP_W'($urandom_range(target - top, top));
            shuffle_components(x, y, z, r, g, b);
         end
         4: begin
            // one component saturated, the others random
            shuffle_components(8'hff, x, y, r, g, b);
         end
         default: begin
            r = x; g = y; b = z;
         end
      endcase
   endtask

   // ---------------------------------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------------------------------

   // corners: black, white, greys, primaries and secondaries, every sextant branch,
   // both sides of the lightness midpoint
   task automatic test_corner_pixels();
      send_pixel(8'd0,   8'd0,   8'd0);     // black
      send_pixel(8'd255, 8'd255, 8'd255);   // white
      send_pixel(8'd128, 8'd128, 8'd128);   // mid grey
      send_pixel(8'd1,   8'd1,   8'd1);     // darkest grey
      send_pixel(8'd255, 8'd0,   8'd0);     // pure red, hue comes out at 360
      send_pixel(8'd1,   8'd0,   8'd0);     // faintest red
      send_pixel(8'd0,   8'd255, 8'd0);     // pure green
      send_pixel(8'd0,   8'd1,   8'd0);
      send_pixel(8'd0,   8'd0,   8'd255);   // pure blue
      send_pixel(8'd0,   8'd0,   8'd1);
      send_pixel(8'd255, 8'd255, 8'd0);     // yellow, red wins the tie
      send_pixel(8'd0,   8'd255, 8'd255);   // cyan, green wins the tie
      send_pixel(8'd255, 8'd0,   8'd255);   // magenta, red wins the tie
      send_pixel(8'd200, 8'd50,  8'd100);   // red max, green min
      send_pixel(8'd200, 8'd100, 8'd50);    // red max, blue min
      send_pixel(8'd100, 8'd200, 8'd50);    // green max, blue min
      send_pixel(8'd50,  8'd200, 8'd100);   // green max, red min
      send_pixel(8'd50,  8'd100, 8'd200);   // blue max, red min
      send_pixel(8'd100, 8'd50,  8'd200);   // blue max, green min
      send_pixel(8'd200, 8'd55,  8'd100);   // max + min exactly 255
      send_pixel(8'd200, 8'd56,  8'd100);   // max + min just over 255
      send_pixel(8'd255, 8'd254, 8'd254);   // nearly white
      send_pixel(8'd170, 8'd85,  8'd85);    // bit patterns alternating
   endtask

   task automatic test_random_pixels(input int count);
      logic [COMP_W-1:0] r, g, b;
      repeat (count) begin
         pick_pixel(r, g, b);
         send_pixel(r, g, b);
      end
   endtask

   // receiver holds off long enough for the pipeline to fill and stall req
   task automatic test_output_hold_off();
      release_req();
      hold_off_left = 6 * PIPE_DEPTH;
      test_random_pixels(60);
   endtask

   // sender stops until the block has handed back everything, then starts again
   task automatic test_pause_until_drained();
      test_random_pixels(20);
      release_req();
      wait_for_colours();
      test_random_pixels(20);
   endtask

   // ---------------------------------------------------------------------------------------
   // sequence
   // ---------------------------------------------------------------------------------------

   initial begin
      reset              = 1'b1;
      req_link.valid     = 1'b0;
      req_link.red       = '0;
      req_link.green     = '0;
      req_link.blue      = '0;
      rsp_link.ready     = 1'b0;
      hold_off_left      = 0;
      mismatches         = 0;
      pixels_sent        = 0;
      colours_checked    = 0;
      input_stall_cycles = 0;
      grey_pixels        = 0;

      // phase one: sender gaps now and then, receiver stalls more often than not
      req_idle_pct = 24;
      rsp_idle_pct = 57;

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_corner_pixels();
      test_random_pixels(130);

      // phase two: roles swapped
      req_idle_pct = 57;
      rsp_idle_pct = 24;
      test_random_pixels(130);

      // phase three: full rate on both sides
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      test_random_pixels(130);
      test_output_hold_off();
      test_pause_until_drained();

      // let the pipeline empty and watch for stray beats
      release_req();
      wait_for_colours();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (pending_colours.size() != 0)
         report_mismatch($sformatf("%0d colours never came back", pending_colours.size()));

      $display("covered %0d pixels (%0d grey), %0d colours checked",
               pixels_sent, grey_pixels, colours_checked);
      $display("req held off for %0d cycles under back-pressure, %0d mismatches",
               input_stall_cycles, mismatches);
      if (mismatches == 0) begin
         $display("rgb_to_hsl_converter_top regression: pass");
      end else begin
         $display("rgb_to_hsl_converter_top regression: fail");
      end
      $finish;
   end

endmodule

[sim.f]
rtl/rgbhsl_pkg.sv
rtl/rgbhsl_if.sv
rtl/rgbhsl_div.sv
rtl/rgb_to_hsl_converter_top.sv
bench/rgb_to_hsl_converter_top_test.sv
